// File: sv/vcp_pkg.sv
// ----------------------------------------------------------------------------
// VCP capability code extractor: shared package
// Character codes, the search state type, the result type and the hex digit
// decoder used by the parser and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package vcp_pkg;

  // Width of the nesting depth counter unless the top level is told otherwise.
  localparam int unsigned DEPTH_BITS_DEFAULT = 4;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  // Search and parse progress.
  typedef enum logic [2:0] {
    MP_WAIT_V    = 3'd0,
    MP_WAIT_C    = 3'd1,
    MP_WAIT_P    = 3'd2,
    MP_WAIT_OPEN = 3'd3,
    MP_PARSING   = 3'd4,
    MP_HALTED    = 3'd5
  } mp_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic       code_valid;
    logic [7:0] code_value;
    logic       code_is_new;
    logic       segment_closed;
    logic       depth_overflow;
  } res_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UC_A && c <= CH_UC_Z) r = c | CASE_BIT;
    return r;
  endfunction

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      h.is_hex = 1'b1;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = c - CH_LC_A + HEX_TEN;
      h.is_hex = 1'b1;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = c - CH_UC_A + HEX_TEN;
      h.is_hex = 1'b1;
    end
    h.value = d[3:0];
    return h;
  endfunction

endpackage

`default_nettype wire

// File: sv/vcp_parser.sv
// ----------------------------------------------------------------------------
// VCP parser core
// Holds the search and parse state and the seen-map, and works out the result
// for one character in a single pass. State moves only when step is high or rst is set.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_parser #(
  parameter int unsigned DEPTH_BITS = vcp_pkg::DEPTH_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    char_byte,
  input  wire logic          end_of_string,
  output vcp_pkg::res_t      res
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  vcp_pkg::mp_t          mp, mp_next;
  logic [DEPTH_BITS-1:0] depth, depth_next, depth_dec;
  logic [3:0]            nibble, nibble_next;
  logic                  held, held_next;
  logic                  closed, closed_next;
  logic                  ovf, ovf_next;
  logic [255:0]          seen;
  logic [7:0]            folded;
  vcp_pkg::hex_t         hx;

  always_comb begin
    folded      = vcp_pkg::fold_lower(char_byte);
    hx          = vcp_pkg::hex_decode(char_byte);
    mp_next     = mp;
    depth_next  = depth;
    nibble_next = nibble;
    held_next   = held;
    closed_next = closed;
    ovf_next    = ovf;
    depth_dec   = (depth != '0) ? depth - DEPTH_ONE : depth;
    res         = '0;

    unique case (mp)
      vcp_pkg::MP_WAIT_V: begin
        mp_next = (folded == vcp_pkg::CH_V) ? vcp_pkg::MP_WAIT_C : vcp_pkg::MP_WAIT_V;
      end
      vcp_pkg::MP_WAIT_C: begin
        if (folded == vcp_pkg::CH_C) begin
          mp_next = vcp_pkg::MP_WAIT_P;
        end else begin
          mp_next = (folded == vcp_pkg::CH_V) ? vcp_pkg::MP_WAIT_C : vcp_pkg::MP_WAIT_V;
        end
      end
      vcp_pkg::MP_WAIT_P: begin
        if (folded == vcp_pkg::CH_P) begin
          mp_next = vcp_pkg::MP_WAIT_OPEN;
        end else begin
          mp_next = (folded == vcp_pkg::CH_V) ? vcp_pkg::MP_WAIT_C : vcp_pkg::MP_WAIT_V;
        end
      end
      vcp_pkg::MP_WAIT_OPEN: begin
        if (folded == vcp_pkg::CH_OPEN) begin
          mp_next     = vcp_pkg::MP_PARSING;
          depth_next  = DEPTH_ONE;
          held_next   = 1'b0;
          nibble_next = '0;
        end else begin
          mp_next = (folded == vcp_pkg::CH_V) ? vcp_pkg::MP_WAIT_C : vcp_pkg::MP_WAIT_V;
        end
      end
      vcp_pkg::MP_PARSING: begin
        if (char_byte == vcp_pkg::CH_NUL) begin
          // A NUL ends parsing without the list being closed.
          mp_next   = vcp_pkg::MP_HALTED;
          held_next = 1'b0;
        end else if (char_byte == vcp_pkg::CH_OPEN) begin
          held_next = 1'b0;
          if (depth == DEPTH_MAX) begin
            ovf_next = 1'b1;
          end else begin
            depth_next = depth + DEPTH_ONE;
          end
        end else if (char_byte == vcp_pkg::CH_CLOSE) begin
          held_next  = 1'b0;
          depth_next = depth_dec;
          if (depth_dec == '0) begin
            closed_next = 1'b1;
            mp_next     = vcp_pkg::MP_HALTED;
          end
        end else if (hx.is_hex) begin
          // Digits inside nested value lists are skipped.
          if (depth == DEPTH_ONE) begin
            if (held) begin
              res.code_valid  = 1'b1;
              res.code_value  = {nibble, hx.value};
              res.code_is_new = ~seen[{nibble, hx.value}];
              held_next       = 1'b0;
              nibble_next     = '0;
            end else begin
              nibble_next = hx.value;
              held_next   = 1'b1;
            end
          end
        end else begin
          held_next   = 1'b0;
          nibble_next = '0;
        end
      end
      vcp_pkg::MP_HALTED: begin
      end
      default: begin
      end
    endcase

    res.segment_closed = closed_next;
    res.depth_overflow = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_string)) begin
      mp     <= vcp_pkg::MP_WAIT_V;
      depth  <= '0;
      nibble <= '0;
      held   <= 1'b0;
      closed <= 1'b0;
      ovf    <= 1'b0;
    end else if (step) begin
      mp     <= mp_next;
      depth  <= depth_next;
      nibble <= nibble_next;
      held   <= held_next;
      closed <= closed_next;
      ovf    <= ovf_next;
    end
  end

  // The seen-map is a flag per code; the whole map clears at once after the
  // final character of a string.
  always_ff @(posedge clk) begin
    if (rst || (step && end_of_string)) begin
      seen <= '0;
    end else if (step && res.code_valid) begin
      seen[res.code_value] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: sv/vcp_capability_code_extractor.sv
// Order: an accepted character waits in the input register and is parsed into
// the result register once that register is free.
// Throughput: one character per cycle while result_stall is low; the input
// register can take one more character while a result waits to be taken.
// Reset: synchronous rst empties both registers, returns the search to its
// start and clears the seen-map; the same state clears after end_of_string.
// ----------------------------------------------------------------------------
// VCP capability code extractor
// Finds the vcp( list in a capability string and emits each code byte of the
// top level of that list, flagging codes not seen earlier in the string.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_capability_code_extractor #(
  parameter int unsigned DEPTH_BITS = vcp_pkg::DEPTH_BITS_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] char_byte,
  input  wire logic       end_of_string,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic            code_valid,
  output logic [7:0]      code_value,
  output logic            code_is_new,
  output logic            segment_closed,
  output logic            depth_overflow
);

  logic          hold_valid;
  logic [7:0]    hold_char;
  logic          hold_eos;
  logic          advance;
  logic          accept;
  vcp_pkg::res_t res;

  assign advance    = hold_valid && (!result_valid || !result_stall);
  assign item_stall = hold_valid && result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_char <= char_byte;
      hold_eos  <= end_of_string;
    end
  end

  vcp_parser #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .char_byte    (hold_char),
    .end_of_string(hold_eos),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      code_valid     <= res.code_valid;
      code_value     <= res.code_value;
      code_is_new    <= res.code_is_new;
      segment_closed <= res.segment_closed;
      depth_overflow <= res.depth_overflow;
    end
  end

  // The input register only pushes back when the result register is full and
  // held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (hold_valid && result_valid && result_stall))
    else $error("input stalled while the result register could take a beat");

  // An accepted character must be sitting in the input register in the following cycle.
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(accept)) |-> hold_valid)
    else $error("accepted character lost from the input register");

  // A beat without a code carries a zero code and no new flag.
  a_empty_code: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !code_valid) |-> (code_value == 8'd0 && !code_is_new))
    else $error("code fields set on a beat without a code");

  a_new_needs_code: assert property (@(posedge clk) disable iff (rst)
    (result_valid && code_is_new) |-> code_valid)
    else $error("new-code flag raised without a code");

endmodule

`default_nettype wire

// File: test/vcp_ledger_pkg.sv
// ----------------------------------------------------------------------------
// VCP code ledger
// Predicts the result beat of every accepted character of a capability string
// and checks the result beats of the extractor against those predictions.
// ----------------------------------------------------------------------------
package vcp_ledger_pkg;

  import vcp_pkg::*;

  class code_ledger;

    // Parser state as the extractor should hold it.
    mp_t         progress;
    int unsigned depth;
    logic [3:0]  high_nibble;
    logic        nibble_held;
    logic        closed;
    logic        overflowed;
    bit          seen[256];
    int unsigned depth_max = (1 << DEPTH_BITS_DEFAULT) - 1;

    // Predicted result beats, oldest first.
    res_t        expected_codes[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      progress    = MP_WAIT_V;
      depth       = 0;
      high_nibble = '0;
      nibble_held = 1'b0;
      closed      = 1'b0;
      overflowed  = 1'b0;
      foreach (seen[i]) seen[i] = 1'b0;
    endfunction

    function logic [7:0] search_target(mp_t p);
      case (p)
        MP_WAIT_V: return CH_V;
        MP_WAIT_C: return CH_C;
        MP_WAIT_P: return CH_P;
        default:   return CH_OPEN;
      endcase
    endfunction

    // Works out the result beat of one accepted character.
    function void note_char(logic [7:0] c, logic last);
      res_t       r;
      logic [7:0] low;
      logic [3:0] nib;
      logic       is_digit;
      r        = '0;
      low      = (c >= CH_UC_A && c <= CH_UC_Z) ? (c | CASE_BIT) : c;
      is_digit = 1'b0;
      nib      = '0;
      if (c >= CH_0 && c <= CH_9) begin
        is_digit = 1'b1;
        nib      = c[3:0];
      end else if (low >= CH_LC_A && low <= CH_LC_F) begin
        is_digit = 1'b1;
        nib      = low[3:0] + 4'd9;
      end

      if (progress < MP_PARSING) begin
        if (low == search_target(progress)) begin
          progress = mp_t'(progress + 3'd1);
          if (progress == MP_PARSING) begin
            depth       = 1;
            nibble_held = 1'b0;
            high_nibble = '0;
          end
        end else begin
          // The pattern cannot overlap itself, so only a v restarts it.
          progress = (low == CH_V) ? MP_WAIT_C : MP_WAIT_V;
        end
      end else if (progress == MP_PARSING) begin
        if (c == CH_NUL) begin
          progress    = MP_HALTED;
          nibble_held = 1'b0;
        end else if (c == CH_OPEN) begin
          nibble_held = 1'b0;
          if (depth >= depth_max) overflowed = 1'b1;
          else depth++;
        end else if (c == CH_CLOSE) begin
          nibble_held = 1'b0;
          if (depth > 0) depth--;
          if (depth == 0) begin
            closed   = 1'b1;
            progress = MP_HALTED;
          end
        end else if (is_digit) begin
          if (depth == 1) begin
            if (nibble_held) begin
              r.code_valid  = 1'b1;
              r.code_value  = {high_nibble, nib};
              r.code_is_new = !seen[r.code_value];
              seen[r.code_value] = 1'b1;
              nibble_held = 1'b0;
              high_nibble = '0;
            end else begin
              high_nibble = nib;
              nibble_held = 1'b1;
            end
          end
        end else begin
          nibble_held = 1'b0;
          high_nibble = '0;
        end
      end

      r.segment_closed = closed;
      r.depth_overflow = overflowed;
      expected_codes.push_back(r);
      if (last) clear_string();
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result beat with nothing expected: valid=%0b code=%02h new=%0b",
                   got.code_valid, got.code_value, got.code_is_new);
        return;
      end
      want = expected_codes.pop_front();
      if (got.code_valid !== want.code_valid || got.code_value !== want.code_value ||
          got.code_is_new !== want.code_is_new ||
          got.segment_closed !== want.segment_closed ||
          got.depth_overflow !== want.depth_overflow) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: expected valid=%0b code=%02h new=%0b closed=%0b ovf=%0b",
                   want.code_valid, want.code_value, want.code_is_new,
                   want.segment_closed, want.depth_overflow);
          $display("       got      valid=%0b code=%02h new=%0b closed=%0b ovf=%0b",
                   got.code_valid, got.code_value, got.code_is_new,
                   got.segment_closed, got.depth_overflow);
        end
      end
    endfunction

  endclass

endpackage

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// VCP capability code extractor testbench
// Feeds capability strings, mostly well-formed with random content, through
// the extractor under several idling patterns and checks every result beat.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import vcp_pkg::*;
  import vcp_ledger_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [7:0] char_byte = '0;
  logic       end_of_string = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       code_valid;
  logic [7:0] code_value;
  logic       code_is_new;
  logic       segment_closed;
  logic       depth_overflow;

  code_ledger  ledger;
  logic [7:0]  line_q[$];
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles = 0;

  vcp_capability_code_extractor dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .char_byte      (char_byte),
    .end_of_string  (end_of_string),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .code_valid     (code_valid),
    .code_value     (code_value),
    .code_is_new    (code_is_new),
    .segment_closed (segment_closed),
    .depth_overflow (depth_overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      ledger.check_result({code_valid, code_value, code_is_new, segment_closed,
                           depth_overflow});
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return CH_0 + 8'(v);
    return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + 8'(v - 4'd10);
  endfunction

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    return $urandom_range(1) ? (c & ~CASE_BIT) : c;
  endfunction

  function automatic void add_code();
    logic [7:0] code;
    // A small pool of codes makes repeats within a string common.
    code = ($urandom_range(3) == 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    line_q.push_back(hex_char(code[7:4]));
    line_q.push_back(hex_char(code[3:0]));
  endfunction

  // Builds one capability string: mostly prefix, vcp list and trailer, with
  // some pure noise strings mixed in.
  function automatic void build_string();
    int unsigned n;
    int unsigned k;
    line_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(4))
        0: line_q.push_back(mixed_case(CH_V));
        1: line_q.push_back(mixed_case(CH_C));
        2: line_q.push_back(mixed_case(CH_P));
        3: line_q.push_back(CH_OPEN);
        default: line_q.push_back(8'($urandom_range(255)));
      endcase
    end
    line_q.push_back(mixed_case(CH_V));
    line_q.push_back(mixed_case(CH_C));
    line_q.push_back(mixed_case(CH_P));
    line_q.push_back(CH_OPEN);
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(31))
        8: begin
          line_q.push_back(CH_OPEN);
          repeat ($urandom_range(0, 4)) line_q.push_back(hex_char(4'($urandom_range(15))));
          line_q.push_back(CH_CLOSE);
        end
        9: begin
          line_q.push_back(hex_char(4'($urandom_range(15))));
          line_q.push_back(8'h20);
        end
        10: begin
          line_q.push_back(hex_char(4'($urandom_range(15))));
          line_q.push_back($urandom_range(1) ? CH_OPEN : CH_CLOSE);
        end
        11: begin
          // Deep enough to saturate the depth counter now and then.
          n = $urandom_range(12, 17);
          repeat (n) line_q.push_back(CH_OPEN);
          add_code();
          k = $urandom_range(n - 2, n);
          repeat (k) line_q.push_back(CH_CLOSE);
        end
        12: line_q.push_back(CH_NUL);
        13: line_q.push_back(8'($urandom_range(255)));
        14: line_q.push_back(hex_char(4'($urandom_range(15))));
        default: begin
          add_code();
          if ($urandom_range(1)) line_q.push_back(8'h20);
        end
      endcase
    end
    if ($urandom_range(7) != 0) line_q.push_back(CH_CLOSE);
    repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(255)));
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_char(logic [7:0] c, logic last);
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid    <= 1'b1;
    char_byte     <= c;
    end_of_string <= last;
    do @(posedge clk); while (item_stall);
    ledger.note_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned n_items);
    int unsigned sent;
    sent      = 0;
    gap_pct   = gap;
    stall_pct = stall;
    while (sent < n_items) begin
      build_string();
      send_line();
      sent += line_q.size();
    end
    item_valid <= 1'b0;
    while (ledger.expected_codes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    ledger = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Restart on a repeated v, mixed case, a pair dropped by a stray letter,
    // a nested list skipped, a repeated code, and an odd digit dropped by the
    // closing parenthesis with a character after the close.
    line_q = '{8'hFF, "v", "V", "c", "P", "(", "a", "0", "5", "G", "1", "F", "(",
               "f", "f", ")", "1", "f", "3", ")", "z"};
    send_line();
    // NUL during the search is a mismatch; NUL in the list halts the parser.
    line_q = '{8'h00, "V", "C", "P", "(", "7", 8'h00, "4", "2"};
    send_line();

    run_phase(0, 0, 425);
    run_phase(77, 0, 425);
    run_phase(0, 77, 425);
    run_phase(10, 10, 425);

    repeat (8) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.expected_codes.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
sv/vcp_pkg.sv
sv/vcp_parser.sv
sv/vcp_capability_code_extractor.sv
test/vcp_ledger_pkg.sv
test/testbench.sv
